>>> rtl/biq_pkg.sv
// ----------------------------------------------------------------------------
// biq_pkg
// Shared types and constants for the fixed-point biquad filter.
// ----------------------------------------------------------------------------
package biq_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned ACC_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // Output is bits [29:14] of the wrapped sum (sum << 2, upper half).
  localparam int unsigned OUT_LSB   = 14;

  typedef logic signed [SAMPLE_W-1:0]  sample_t;
  typedef logic signed [COEF_W-1:0]    coef_t;
  typedef logic signed [ACC_W-1:0]     acc_t;
  typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;

  // Register map
  localparam cfg_idx_t REG_COEF_FF0 = 3'd0;
  localparam cfg_idx_t REG_COEF_FF1 = 3'd1;
  localparam cfg_idx_t REG_COEF_FF2 = 3'd2;
  localparam cfg_idx_t REG_COEF_FB1 = 3'd3;
  localparam cfg_idx_t REG_COEF_FB2 = 3'd4;

  // Reset values (Q14: 16384 is unity gain)
  localparam coef_t COEF_FF0_RST = 16'sd16384;
  localparam coef_t COEF_ZERO    = 16'sd0;

  typedef struct packed {
    coef_t ff0;
    coef_t ff1;
    coef_t ff2;
    coef_t fb1;
    coef_t fb2;
  } coef_set_t;

  typedef struct packed {
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } hist_t;

endpackage

>>> rtl/biq_if.sv
// ----------------------------------------------------------------------------
// biq_if
// Handshake channels of the biquad filter: sample in, sample out, config.
// ----------------------------------------------------------------------------
interface biq_in_if;
  logic             valid;
  logic             ready;
  biq_pkg::sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface biq_out_if;
  logic             valid;
  logic             ready;
  biq_pkg::sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface biq_cfg_if;
  logic              valid;
  logic              ready;
  biq_pkg::cfg_idx_t index;
  biq_pkg::coef_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/biq_coef_regs.sv
// ----------------------------------------------------------------------------
// biq_coef_regs
// Coefficient register file, written over the config channel.
// ----------------------------------------------------------------------------
module biq_coef_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  biq_cfg_if.sink             cfg_i,
  output biq_pkg::coef_set_t  coef_o
);

  biq_pkg::coef_set_t coef_q, coef_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    coef_d = coef_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        biq_pkg::REG_COEF_FF0: coef_d.ff0 = cfg_i.data;
        biq_pkg::REG_COEF_FF1: coef_d.ff1 = cfg_i.data;
        biq_pkg::REG_COEF_FF2: coef_d.ff2 = cfg_i.data;
        biq_pkg::REG_COEF_FB1: coef_d.fb1 = cfg_i.data;
        biq_pkg::REG_COEF_FB2: coef_d.fb2 = cfg_i.data;
        default: ; // unmapped index: write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.ff0 <= biq_pkg::COEF_FF0_RST;
      coef_q.ff1 <= biq_pkg::COEF_ZERO;
      coef_q.ff2 <= biq_pkg::COEF_ZERO;
      coef_q.fb1 <= biq_pkg::COEF_ZERO;
      coef_q.fb2 <= biq_pkg::COEF_ZERO;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

>>> rtl/biq_mac.sv
// ----------------------------------------------------------------------------
// biq_mac
// Five 16x16 products, wrapped 32-bit sum, output slice [29:14].
// ----------------------------------------------------------------------------
module biq_mac (
  input  biq_pkg::sample_t   x_i,
  input  biq_pkg::hist_t     hist_i,
  input  biq_pkg::coef_set_t coef_i,
  output biq_pkg::sample_t   y_o
);

  biq_pkg::sample_t x1, x2, y1, y2;
  biq_pkg::coef_t   ff0, ff1, ff2, fb1, fb2;
  biq_pkg::acc_t    p_ff0, p_ff1, p_ff2, p_fb1, p_fb2;
  biq_pkg::acc_t    acc;

  // unpack into signed locals so the products stay signed
  assign x1  = hist_i.x1;
  assign x2  = hist_i.x2;
  assign y1  = hist_i.y1;
  assign y2  = hist_i.y2;
  assign ff0 = coef_i.ff0;
  assign ff1 = coef_i.ff1;
  assign ff2 = coef_i.ff2;
  assign fb1 = coef_i.fb1;
  assign fb2 = coef_i.fb2;

  assign p_ff0 = biq_pkg::acc_t'(x_i) * biq_pkg::acc_t'(ff0);
  assign p_ff1 = biq_pkg::acc_t'(x1)  * biq_pkg::acc_t'(ff1);
  assign p_ff2 = biq_pkg::acc_t'(x2)  * biq_pkg::acc_t'(ff2);
  assign p_fb1 = biq_pkg::acc_t'(y1)  * biq_pkg::acc_t'(fb1);
  assign p_fb2 = biq_pkg::acc_t'(y2)  * biq_pkg::acc_t'(fb2);

  // wraps mod 2^32, no saturation
  assign acc = p_ff0 + p_ff1 + p_ff2 - p_fb1 - p_fb2;

  assign y_o = acc[biq_pkg::OUT_LSB +: biq_pkg::SAMPLE_W];

endmodule

>>> rtl/biquad_fixed_point_filter.sv
// ----------------------------------------------------------------------------
// biquad_fixed_point_filter
// Direct form I biquad on signed 16-bit samples with Q14 coefficients.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Payload                     | Handshake
//  --------+-----+-----------------------------+------------------
//  in_i    | in  | sample_in  (s16)            | valid / ready
//  out_o   | out | sample_out (s16)            | valid / ready
//  cfg_i   | in  | index (3b), data (s16)      | valid / ready (always 1)
//
//  One item per cycle sustained while out_o is not stalled; an accepted item
//  passes the input register, then the result register. The feedback loop
//  (history regs -> five multiplies -> sum) is combinational from register
//  to register, which sets the rate.
//  Reset clears history and valid flags and loads the coefficient defaults.
//  A stalled output holds its item; one more item waits in the input
//  register, then in_i.ready drops until the output is taken.
//
module biquad_fixed_point_filter (
  input  logic       clk_i,
  input  logic       rst_ni,
  biq_in_if.sink     in_i,
  biq_out_if.source  out_o,
  biq_cfg_if.sink    cfg_i
);

  // --------------------------------------------------------------------------
  // Coefficients
  // --------------------------------------------------------------------------
  biq_pkg::coef_set_t coef;

  biq_coef_regs u_coef_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .coef_o (coef)
  );

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic             in_vld_q, in_vld_d;
  logic             out_vld_q, out_vld_d;
  biq_pkg::sample_t x_q;
  logic             in_fire;
  logic             adv;        // input register item moves to output reg
  logic             out_free;   // output reg empty or being drained

  assign out_free   = !out_vld_q || out_o.ready;
  assign adv        = in_vld_q && out_free;
  assign in_i.ready = !in_vld_q || adv;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_fire)  in_vld_d = 1'b1;
    else if (adv) in_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q <= in_i.sample_in;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath. History only moves when an item leaves the input register,
  // so the next item always sees the outputs of the one before it.
  // --------------------------------------------------------------------------
  biq_pkg::hist_t   hist_q, hist_d;
  biq_pkg::sample_t y_c;

  biq_mac u_mac (
    .x_i    (x_q),
    .hist_i (hist_q),
    .coef_i (coef),
    .y_o    (y_c)
  );

  always_comb begin
    hist_d = hist_q;
    if (adv) begin
      hist_d.x2 = hist_q.x1;
      hist_d.x1 = x_q;
      hist_d.y2 = hist_q.y1;
      hist_d.y1 = y_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else begin
      hist_q <= hist_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  biq_pkg::sample_t out_sample_q;

  always_comb begin
    out_vld_d = out_vld_q;
    if (adv)              out_vld_d = 1'b1;
    else if (out_o.ready) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_sample_q <= y_c;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.sample_out = out_sample_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // input side only stalls when both registers are full and output is stuck
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (in_vld_q && out_vld_q && !out_o.ready))
    else $error("input stalled without a full, blocked pipeline");

  // history shifts exactly the item that left the input register
  a_hist_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (hist_q.x1 == $past(x_q)) && (hist_q.x2 == $past(hist_q.x1)))
    else $error("input history did not shift with the item");

  // result register and feedback history carry the same value
  a_fb_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (out_sample_q == hist_q.y1) && out_vld_q)
    else $error("output and feedback history disagree");

  // history frozen when no item advances
  a_hist_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(hist_q))
    else $error("history changed without an item");

endmodule

>>> sim/tb_biquad_fixed_point_filter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_biquad_fixed_point_filter
// Self-checking bench for the direct form I biquad. A directed table covers
// unity gain after reset, full-scale samples and coefficients, accumulator
// wrap and writes to unused register slots. Random phases follow, each with
// a fresh coefficient set. Every output item is compared in order against a
// bit-true Q14 filter model kept in this bench.
// ----------------------------------------------------------------------------
module tb_biquad_fixed_point_filter;

  localparam int unsigned HALF_PERIOD = 6;       // 12 ns clock
  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned SETTLE_CYCLES = 6;     // latency is short, plus margin
  localparam int unsigned HOLD_CYCLES = 80;      // long output back-pressure
  localparam int unsigned REPORT_MAX = 10;
  localparam int unsigned CYCLE_LIMIT = 250000;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 74;
  localparam int unsigned HOLD_PHASE = 2;
  localparam int unsigned PAUSE_PHASE = 4;

  // Register slots past the map; writes there must be dropped.
  localparam biq_pkg::cfg_idx_t REG_UNUSED_LO = 3'd5;
  localparam biq_pkg::cfg_idx_t REG_UNUSED_HI = 3'd7;

  // Butterworth low-pass near fs/10, Q14, in register order.
  localparam biq_pkg::coef_t LOWPASS_SET [5] = '{16'sd1106, 16'sd2213, 16'sd1106,
                                                 -16'sd18727, 16'sd6763};

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    biq_pkg::cfg_idx_t index;  // register slot, write rows only
    biq_pkg::sample_t  value;  // sample, or register data
    logic              known;  // output typed in below
    biq_pkg::sample_t  want;
  } dir_row_t;

  // Directed table. Outputs are typed in where they are obvious: unity
  // gain right after reset, all-zero coefficients, and the case where the
  // only set bit of the sum falls off the top in the shift.
  localparam int unsigned DIR_ROWS = 33;
  dir_row_t directed_rows [DIR_ROWS] = '{
    '{ROW_SAMPLE, biq_pkg::REG_COEF_FF0, 16'h0000, 1'b1, 16'h0000},
    '{ROW_SAMPLE, biq_pkg::REG_COEF_FF0, 16'h7FFF, 1'b1, 16'h7FFF},
    '{ROW_SAMPLE, biq_pkg::REG_COEF_FF0, 16'h8000, 1'b1, 16'h8000},
    '{ROW_SAMPLE, biq_pkg::REG_COEF_FF0, 16'h0001, 1'b1, 16'h0001},
    '{ROW_SAMPLE, biq_pkg::REG_COEF_FF0, 16'hFFFF, 1'b1, 16'hFFFF},
    '{ROW_SAMPLE, biq_pkg::REG_COEF_FF0, 16'h5555, 1'b1, 16'h5555},
    '{ROW_SAMPLE, biq_pkg::REG_COEF_FF0, 16'hAAAA, 1'b1, 16'hAAAA},
    // unused slots: gain must stay at unity
    '{ROW_WRITE,  REG_UNUSED_LO, 16'h7FFF, 1'b0, 16'h0000},
    '{ROW_WRITE,  REG_UNUSED_HI, 16'h8000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, biq_pkg::REG_COEF_FF0, 16'sd1234, 1'b1, 16'sd1234},
    // most negative gain: (-32768)^2 is 2^30, lost entirely in the shift
    '{ROW_WRITE,  biq_pkg::REG_COEF_FF0, 16'h8000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, biq_pkg::REG_COEF_FF0, 16'h8000, 1'b1, 16'h0000},
    '{ROW_SAMPLE, biq_pkg::REG_COEF_FF0, 16'h7FFF, 1'b0, 16'h0000},
    '{ROW_WRITE,  biq_pkg::REG_COEF_FF0, 16'h7FFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, biq_pkg::REG_COEF_FF0, 16'h7FFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, biq_pkg::REG_COEF_FF0, 16'h8000, 1'b0, 16'h0000},
    // every tap at full scale: the sum wraps
    '{ROW_WRITE,  biq_pkg::REG_COEF_FF1, 16'h7FFF, 1'b0, 16'h0000},
    '{ROW_WRITE,  biq_pkg::REG_COEF_FF2, 16'h8000, 1'b0, 16'h0000},
    '{ROW_WRITE,  biq_pkg::REG_COEF_FB1, 16'h8000, 1'b0, 16'h0000},
    '{ROW_WRITE,  biq_pkg::REG_COEF_FB2, 16'h7FFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, biq_pkg::REG_COEF_FF0, 16'h7FFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, biq_pkg::REG_COEF_FF0, 16'h8000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, biq_pkg::REG_COEF_FF0, 16'h7FFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, biq_pkg::REG_COEF_FF0, 16'h8000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, biq_pkg::REG_COEF_FF0, 16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, biq_pkg::REG_COEF_FF0, 16'h0000, 1'b0, 16'h0000},
    // all taps off: output is zero whatever the history
    '{ROW_WRITE,  biq_pkg::REG_COEF_FF0, 16'h0000, 1'b0, 16'h0000},
    '{ROW_WRITE,  biq_pkg::REG_COEF_FF1, 16'h0000, 1'b0, 16'h0000},
    '{ROW_WRITE,  biq_pkg::REG_COEF_FF2, 16'h0000, 1'b0, 16'h0000},
    '{ROW_WRITE,  biq_pkg::REG_COEF_FB1, 16'h0000, 1'b0, 16'h0000},
    '{ROW_WRITE,  biq_pkg::REG_COEF_FB2, 16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, biq_pkg::REG_COEF_FF0, 16'h7FFF, 1'b1, 16'h0000},
    '{ROW_SAMPLE, biq_pkg::REG_COEF_FF0, 16'h8000, 1'b1, 16'h0000}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  biq_in_if  in_ch ();
  biq_out_if out_ch ();
  biq_cfg_if cfg_ch ();

  biquad_fixed_point_filter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // Filter model state: coefficients as written, plus the delay line.
  biq_pkg::coef_set_t coefs;
  biq_pkg::hist_t     hist;

  biq_pkg::sample_t pending_outputs [$];
  int unsigned      results_seen = 0;
  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count = 0;

  // Knobs shared between the item source and the output side.
  bit send_quiet = 1'b0;
  bit recv_quiet = 1'b0;
  bit hold_req = 1'b0;

  always begin
    #(HALF_PERIOD) clk_i = 1'b1;
    #(HALF_PERIOD) clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Mostly back-to-back, sometimes a few cycles, rarely a long gap.
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // One sample through the Q14 biquad: five 16x16 products summed in a
  // 32-bit accumulator that wraps; output is sum bits [29:14].
  function automatic biq_pkg::sample_t filter_step(input biq_pkg::sample_t x);
    biq_pkg::acc_t    sum;
    biq_pkg::sample_t y;
    sum = biq_pkg::acc_t'(x) * biq_pkg::acc_t'(coefs.ff0)
        + biq_pkg::acc_t'(hist.x1) * biq_pkg::acc_t'(coefs.ff1)
        + biq_pkg::acc_t'(hist.x2) * biq_pkg::acc_t'(coefs.ff2)
        - biq_pkg::acc_t'(hist.y1) * biq_pkg::acc_t'(coefs.fb1)
        - biq_pkg::acc_t'(hist.y2) * biq_pkg::acc_t'(coefs.fb2);
    y = sum[biq_pkg::OUT_LSB +: biq_pkg::SAMPLE_W];
    hist.x2 = hist.x1;
    hist.x1 = x;
    hist.y2 = hist.y1;
    hist.y1 = y;
    return y;
  endfunction

  task automatic report_mismatch(input string what, input biq_pkg::sample_t want,
                                 input biq_pkg::sample_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("%s: output %0d expected %0d got %0d", what, results_seen, want, got);
  endtask

  // Lowers both request lines, waits for every output to come back, then
  // lets the pipeline go quiet before any register write.
  task automatic settle_idle();
    in_ch.valid  <= 1'b0;
    cfg_ch.valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Leaves valid high so back-to-back writes need no extra cycle.
  task automatic write_reg(input biq_pkg::cfg_idx_t idx, input biq_pkg::coef_t data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      biq_pkg::REG_COEF_FF0: coefs.ff0 = data;
      biq_pkg::REG_COEF_FF1: coefs.ff1 = data;
      biq_pkg::REG_COEF_FF2: coefs.ff2 = data;
      biq_pkg::REG_COEF_FB1: coefs.fb1 = data;
      biq_pkg::REG_COEF_FB2: coefs.fb2 = data;
      default: ;  // unused slot, dropped
    endcase
  endtask

  task automatic send_sample(input biq_pkg::sample_t x, input logic known,
                             input biq_pkg::sample_t want);
    biq_pkg::sample_t y;
    int unsigned      gap;
    cfg_ch.valid     <= 1'b0;
    in_ch.valid      <= 1'b1;
    in_ch.sample_in  <= x;
    do @(posedge clk_i); while (!in_ch.ready);
    y = filter_step(x);
    pending_outputs.push_back(known ? want : y);
    gap = pick_gap(send_quiet);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Output side: checks each accepted item and drives ready, with random
  // stalls and, on request, one long hold-off so the input backs up.
  initial begin : output_side
    int unsigned      stall_left;
    int unsigned      hold_left;
    biq_pkg::sample_t want;
    stall_left = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_outputs.size() == 0) begin
          report_mismatch("unexpected output", 'x, out_ch.sample_out);
        end else begin
          want = pending_outputs.pop_front();
          if (out_ch.sample_out !== want)
            report_mismatch("sample_out mismatch", want, out_ch.sample_out);
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap(recv_quiet);
      end
    end
  end

  initial begin : item_source
    biq_pkg::sample_t x;
    biq_pkg::coef_t   c;
    in_ch.valid      <= 1'b0;
    in_ch.sample_in  <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= biq_pkg::REG_COEF_FF0;
    cfg_ch.data      <= '0;

    // model starts from the reset state of the block
    coefs = '{ff0: biq_pkg::COEF_FF0_RST, ff1: biq_pkg::COEF_ZERO,
              ff2: biq_pkg::COEF_ZERO, fb1: biq_pkg::COEF_ZERO,
              fb2: biq_pkg::COEF_ZERO};
    hist  = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        settle_idle();
        write_reg(directed_rows[i].index, directed_rows[i].value);
      end else begin
        send_sample(directed_rows[i].value, directed_rows[i].known,
                    directed_rows[i].want);
      end
    end

    // Random phases. The first uses a real low-pass so the feedback path
    // runs as it would in service; later ones mix extremes, unity, small
    // and arbitrary coefficients.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle_idle();
      for (int r = biq_pkg::REG_COEF_FF0; r <= biq_pkg::REG_COEF_FB2; r++) begin
        if (ph == 0) begin
          c = LOWPASS_SET[r];
        end else begin
          case ($urandom_range(0, 5))
            0: c = 16'h8000;
            1: c = 16'h7FFF;
            2: c = biq_pkg::COEF_ZERO;
            3: c = biq_pkg::COEF_FF0_RST;
            4: c = biq_pkg::coef_t'(int'($urandom_range(0, 1024)) - 512);
            default: c = biq_pkg::coef_t'($urandom);
          endcase
        end
        write_reg(biq_pkg::cfg_idx_t'(r), c);
      end
      if ($urandom_range(0, 2) == 0)
        write_reg(biq_pkg::cfg_idx_t'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                  biq_pkg::coef_t'($urandom));

      send_quiet = (ph % 3 == 1);
      recv_quiet = (ph % 3 == 1);
      if (ph == HOLD_PHASE) begin
        // source keeps pushing while the output is held off
        send_quiet = 1'b1;
        hold_req = 1'b1;
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == PAUSE_PHASE && n == PHASE_ITEMS / 2) settle_idle();
        case ($urandom_range(0, 7))
          0: x = 16'h7FFF;
          1: x = 16'h8000;
          2: x = biq_pkg::sample_t'(int'($urandom_range(0, 512)) - 256);
          default: x = biq_pkg::sample_t'($urandom);
        endcase
        send_sample(x, 1'b0, '0);
      end
    end

    settle_idle();
    if (mismatch_count == 0 && pending_outputs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/biq_pkg.sv
rtl/biq_if.sv
rtl/biq_coef_regs.sv
rtl/biq_mac.sv
rtl/biquad_fixed_point_filter.sv
sim/tb_biquad_fixed_point_filter.sv
